>>> rtl/int8_mlp_binary_classifier_macros.svh
// ----------------------------------------------------------------------------
// int8_mlp_binary_classifier assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef INT8_MLP_BINARY_CLASSIFIER_MACROS_SVH
`define INT8_MLP_BINARY_CLASSIFIER_MACROS_SVH

// Property checked on every clock edge outside reset
`define IMLP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included
`define IMLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/imlp_pkg.sv
// ----------------------------------------------------------------------------
// imlp_pkg
// Types, codes, widths and the round/clamp helper of the int8 classifier.
// ----------------------------------------------------------------------------
package imlp_pkg;

  localparam int FEATURE_COUNT_DEF = 256;
  localparam int HIDDEN_COUNT_DEF  = 8;

  // stream payload widths
  localparam int IN_TDATA_W  = 112;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // shared multiplier operand and product widths
  localparam int OPA_W  = 34;
  localparam int OPB_W  = 25;
  localparam int PROD_W = OPA_W + OPB_W;

  // input beat kinds
  typedef enum logic [1:0] {
    FN_L1_WEIGHT = 2'd0,
    FN_UNIT      = 2'd1,
    FN_FEATURE   = 2'd2,
    FN_SAMPLE    = 2'd3
  } func_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_OUTPUT_BIAS = 2'd0,
    CFG_HIDDEN_MULT = 2'd1,
    CFG_HIDDEN_SHFT = 2'd2,
    CFG_INPUT_SHFT  = 2'd3
  } cfg_idx_t;

  localparam logic [7:0] QMAX = 8'd127;

  // Shift right with rounding half away from zero, then clamp to +/-127
  function automatic logic signed [7:0] round_clamp(input logic signed [PROD_W-1:0] p,
                                                     input logic [5:0] s);
    logic        neg;
    logic [63:0] m;
    logic [7:0]  c;
    neg = p[PROD_W-1];
    m   = 64'(p);
    if (neg) m = -m;
    if (s != 6'd0) m = (m + (64'd1 << (s - 6'd1))) >> s;
    c = (m > 64'(QMAX)) ? QMAX : m[7:0];
    return neg ? -$signed(c) : $signed(c);
  endfunction

endpackage

>>> rtl/int8_mlp_binary_classifier.sv
// Timing: a sample beat runs S_SUB, S_MULG, S_RQIN, then S_WADR, S_WMUL, S_WACC per unit;
// a beat marked last then runs S_FPRE, S_FMUL, S_FRQ, S_FMUL2, S_FADD per unit and S_DONE.
// Setup beats are taken in S_IDLE. The sequence is set by the single shared multiplier, used
// once per hidden unit in the accumulate loop and twice per unit in the output loop.
// Reset (rst_n low, synchronous) clears the sequencer, the result beat, the hidden
// accumulators and the configuration registers; weight stores hold garbage until written.
// ----------------------------------------------------------------------------
// int8_mlp_binary_classifier
// Two-layer int8 perceptron with a binary decision, built around one shared
// multiplier and one shared round/clamp unit under a small sequencer.
// ----------------------------------------------------------------------------
module int8_mlp_binary_classifier #(
  parameter int FEATURE_COUNT = imlp_pkg::FEATURE_COUNT_DEF,
  parameter int HIDDEN_COUNT  = imlp_pkg::HIDDEN_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata: item_index[10:0], weight[18:11], bias[50:19], offset_value[66:51],
  //        gain_value[90:67], sample[106:91], zero[111:107]
  input  logic [imlp_pkg::IN_TDATA_W-1:0]   in_tdata,
  // tuser: func[1:0]
  input  logic [imlp_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  logic                              in_tlast,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: logit_sum[31:0]
  output logic [imlp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // tuser: class_bit[0]
  output logic                              out_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [imlp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [imlp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import imlp_pkg::*;

  localparam int L1_DEPTH = FEATURE_COUNT * HIDDEN_COUNT;
  localparam int FW  = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam int JW  = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
  localparam int L1W = (L1_DEPTH > 1) ? $clog2(L1_DEPTH) : 1;
  localparam int LW  = 40;

  typedef enum logic [3:0] {
    S_IDLE, S_SUB, S_MULG, S_RQIN, S_WADR, S_WMUL, S_WACC,
    S_FPRE, S_FMUL, S_FRQ, S_FMUL2, S_FADD, S_DONE
  } state_t;

  // input beat fields
  logic [10:0]        f_idx;
  logic signed [7:0]  f_weight;
  logic signed [31:0] f_bias;
  logic signed [15:0] f_offset;
  logic [23:0]        f_gain;
  logic signed [15:0] f_sample;
  func_t              f_func;
  logic               in_acc;

  assign f_idx    = in_tdata[10:0];
  assign f_weight = in_tdata[18:11];
  assign f_bias   = in_tdata[50:19];
  assign f_offset = in_tdata[66:51];
  assign f_gain   = in_tdata[90:67];
  assign f_sample = in_tdata[106:91];
  assign f_func   = func_t'(in_tuser);
  assign in_acc   = in_tvalid && in_tready;

  // registers
  state_t             state_r;
  logic [JW-1:0]      j_r;
  logic [FW-1:0]      feat_r;
  logic signed [15:0] smp_r;
  logic               last_r;
  logic signed [16:0] d_r;
  logic signed [7:0]  q_r;
  logic signed [7:0]  h_r;
  logic signed [32:0] pre_r;
  logic signed [PROD_W-1:0] mul_r;
  logic signed [LW-1:0] logit_r;
  logic               out_valid_r;
  logic [31:0]        out_data_r;
  logic               out_class_r;

  logic signed [31:0] out_bias_r;
  logic [23:0]        hid_mult_r;
  logic [5:0]         hid_shift_r;
  logic [5:0]         in_shift_r;

  logic [31:0]        acc_r [HIDDEN_COUNT];

  // stores
  logic signed [7:0]  l1_mem  [L1_DEPTH];
  logic signed [15:0] ofs_mem [FEATURE_COUNT];
  logic [23:0]        gain_mem[FEATURE_COUNT];
  logic signed [7:0]  l2_w    [HIDDEN_COUNT];
  logic signed [31:0] hbias   [HIDDEN_COUNT];
  logic signed [7:0]  l1_rd_r;
  logic signed [15:0] ofs_rd_r;
  logic [23:0]        gain_rd_r;
  logic [L1W-1:0]     l1_raddr;
  logic [FW-1:0]      feat_raddr;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_class_r;

  assign l1_raddr = L1W'(int'(feat_r) * HIDDEN_COUNT + int'(j_r));
  // beat index while idle, held feature index while busy
  assign feat_raddr = (state_r == S_IDLE) ? FW'(f_idx) : feat_r;

  // first-layer weight store
  always_ff @(posedge clk) begin
    if (in_acc && f_func == FN_L1_WEIGHT && 32'(f_idx) < 32'(L1_DEPTH)) begin
      l1_mem[L1W'(f_idx)] <= f_weight;
    end
    l1_rd_r <= l1_mem[l1_raddr];
  end

  // per-feature offset and gain store
  always_ff @(posedge clk) begin
    if (in_acc && f_func == FN_FEATURE && 32'(f_idx) < 32'(FEATURE_COUNT)) begin
      ofs_mem[FW'(f_idx)]  <= f_offset;
      gain_mem[FW'(f_idx)] <= f_gain;
    end
    ofs_rd_r  <= ofs_mem[feat_raddr];
    gain_rd_r <= gain_mem[feat_raddr];
  end

  // per-unit second-layer weight and bias
  always_ff @(posedge clk) begin
    if (in_acc && f_func == FN_UNIT && 32'(f_idx) < 32'(HIDDEN_COUNT)) begin
      l2_w[JW'(f_idx)]  <= f_weight;
      hbias[JW'(f_idx)] <= f_bias;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_bias_r  <= '0;
      hid_mult_r  <= 24'd65536;
      hid_shift_r <= 6'd16;
      in_shift_r  <= 6'd16;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_OUTPUT_BIAS: out_bias_r  <= cfg_data;
        CFG_HIDDEN_MULT: hid_mult_r  <= cfg_data[23:0];
        CFG_HIDDEN_SHFT: hid_shift_r <= cfg_data[5:0];
        CFG_INPUT_SHFT:  in_shift_r  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  logic signed [OPA_W-1:0] op_a;
  logic signed [OPB_W-1:0] op_b;
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      S_MULG:  begin op_a = OPA_W'(d_r);   op_b = $signed({1'b0, gain_rd_r}); end
      S_WMUL:  begin op_a = OPA_W'(q_r);   op_b = OPB_W'(l1_rd_r); end
      S_FMUL:  begin op_a = OPA_W'(pre_r); op_b = $signed({1'b0, hid_mult_r}); end
      S_FMUL2: begin op_a = OPA_W'(h_r);   op_b = OPB_W'(l2_w[j_r]); end
      default: ;
    endcase
  end

  // round/clamp unit input select
  logic [5:0]        rc_shift;
  logic signed [7:0] rc_out;
  assign rc_shift = (state_r == S_RQIN) ? in_shift_r : hid_shift_r;
  assign rc_out   = round_clamp(mul_r, rc_shift);

  logic last_unit;
  assign last_unit = (j_r == JW'(HIDDEN_COUNT - 1));

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      j_r         <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < HIDDEN_COUNT; i++) acc_r[i] <= '0;
    end else begin
      // S_DONE reloads the slot itself
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          logit_r <= LW'(out_bias_r);
          j_r     <= '0;
          if (in_acc && f_func == FN_SAMPLE) begin
            feat_r <= FW'(f_idx);
            smp_r  <= f_sample;
            last_r <= in_tlast;
            if (32'(f_idx) < 32'(FEATURE_COUNT)) state_r <= S_SUB;
            else if (in_tlast)                   state_r <= S_FPRE;
          end
        end
        S_SUB: begin
          d_r     <= 17'(smp_r) - 17'(ofs_rd_r);
          state_r <= S_MULG;
        end
        S_MULG: begin
          mul_r   <= op_a * op_b;
          state_r <= S_RQIN;
        end
        S_RQIN: begin
          q_r     <= rc_out;
          state_r <= S_WADR;
        end
        // weight read issued from feat_r/j_r; data lands in l1_rd_r
        S_WADR: state_r <= S_WMUL;
        S_WMUL: begin
          mul_r   <= op_a * op_b;
          state_r <= S_WACC;
        end
        S_WACC: begin
          acc_r[j_r] <= acc_r[j_r] + mul_r[31:0];
          if (!last_unit) begin
            j_r     <= j_r + 1'b1;
            state_r <= S_WADR;
          end else begin
            j_r     <= '0;
            state_r <= last_r ? S_FPRE : S_IDLE;
          end
        end
        // output layer: bias, ReLU, requantize, weight, sum
        S_FPRE: begin
          pre_r   <= 33'($signed(acc_r[j_r])) + 33'(hbias[j_r]);
          state_r <= S_FMUL;
        end
        S_FMUL: begin
          mul_r   <= op_a * op_b;
          state_r <= S_FRQ;
        end
        S_FRQ: begin
          h_r     <= (pre_r > 33'sd0) ? rc_out : 8'sd0;
          state_r <= S_FMUL2;
        end
        S_FMUL2: begin
          mul_r   <= op_a * op_b;
          state_r <= S_FADD;
        end
        S_FADD: begin
          logit_r    <= logit_r + LW'(mul_r);
          acc_r[j_r] <= '0;
          if (!last_unit) begin
            j_r     <= j_r + 1'b1;
            state_r <= S_FPRE;
          end else begin
            state_r <= S_DONE;
          end
        end
        // saturate and load the result beat once the slot is free
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_class_r <= !logit_r[LW-1];
            if (logit_r > LW'(33'sh0_7FFF_FFFF))       out_data_r <= 32'h7FFF_FFFF;
            else if (logit_r < -LW'(33'sh0_8000_0000)) out_data_r <= 32'h8000_0000;
            else                                       out_data_r <= logit_r[31:0];
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/imlp_checker.sv
// ----------------------------------------------------------------------------
// imlp_checker
// Port-level checks on the int8 classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "int8_mlp_binary_classifier_macros.svh"

module imlp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic [imlp_pkg::IN_TUSER_W-1:0]  in_tuser,
  input logic                             in_tlast,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [imlp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready
);
  import imlp_pkg::*;

  logic last_smp_acc;
  assign last_smp_acc = in_tvalid && in_tready && in_tuser == FN_SAMPLE && in_tlast;

  // stalled result beat stays put
  `IMLP_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result beat dropped")
  `IMLP_ASSERT(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata), "result changed")
  // class bit follows the sign of the logit
  `IMLP_ASSERT(a_class, clk, rst_n, out_tvalid |-> (out_tuser == !out_tdata[31]), "class mismatch")
  // a closing sample beat occupies the shared unit for following cycles
  `IMLP_ASSERT(a_busy, clk, rst_n, last_smp_acc |=> !in_tready, "no busy")
  // reset empties the result slot
  `IMLP_ASSERT_ALWAYS(a_rst, clk, !rst_n |=> !out_tvalid, "result after reset")

endmodule

bind int8_mlp_binary_classifier imlp_checker u_imlp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tuser   (in_tuser),
  .in_tlast   (in_tlast),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

>>> test/tb_int8_mlp_binary_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_int8_mlp_binary_classifier
// Loads the stores behind the features in use, then streams feature
// vectors under several register settings and idle patterns. A bit-accurate
// classifier model inside the scoreboard predicts each logit and class bit.
// ----------------------------------------------------------------------------
module tb_int8_mlp_binary_classifier;
  import imlp_pkg::*;

  localparam int NF = FEATURE_COUNT_DEF;
  localparam int NH = HIDDEN_COUNT_DEF;
  localparam int NUSED = 16;
  localparam int PHASE_ITEMS = 60;
  localparam int DRAIN_CYCLES = 120;
  localparam int STALL_LIMIT = 20000;

  // Classifier model and expected-logit store
  class mlp_scoreboard;
    logic signed [7:0]  l1_w [NF*NH];
    logic signed [7:0]  l2_w [NH];
    logic signed [31:0] unit_bias [NH];
    logic signed [15:0] feat_off [NF];
    logic [23:0]        feat_gain [NF];
    logic [31:0]        hid_acc [NH];
    logic signed [31:0] out_bias;
    logic [23:0]        hid_mult;
    logic [5:0]         hid_shift;
    logic [5:0]         in_shift;
    logic signed [31:0] exp_logits [$];
    int                 mismatches;
    int                 results_seen;
    int                 beats_seen;

    function new();
      for (int j = 0; j < NH; j++) hid_acc[j] = '0;
      out_bias = 0;
      hid_mult = 24'd65536;
      hid_shift = 6'd16;
      in_shift = 6'd16;
      mismatches = 0;
      results_seen = 0;
      beats_seen = 0;
    endfunction

    // shift with rounding half away from zero, clamp to +/-127
    function longint qround(longint p, int s);
      bit neg;
      longint unsigned m;
      neg = p < 0;
      m = neg ? -p : p;
      if (s > 0) m = (m + (64'd1 << (s - 1))) >> s;
      if (m > 127) m = 127;
      return neg ? -longint'(m) : longint'(m);
    endfunction

    function void write_reg(cfg_idx_t idx, logic [31:0] val);
      case (idx)
        CFG_OUTPUT_BIAS: out_bias = val;
        CFG_HIDDEN_MULT: hid_mult = val[23:0];
        CFG_HIDDEN_SHFT: hid_shift = val[5:0];
        CFG_INPUT_SHFT:  in_shift = val[5:0];
      endcase
    endfunction

    function void note_beat(func_t fn, logic [10:0] idx, logic signed [7:0] w,
                            logic signed [31:0] b, logic signed [15:0] off,
                            logic [23:0] gain, logic signed [15:0] smp, bit is_last);
      longint q, pre, h, logit;
      beats_seen++;
      case (fn)
        FN_L1_WEIGHT: l1_w[idx] = w;
        FN_UNIT: if (idx < NH) begin
          l2_w[idx] = w;
          unit_bias[idx] = b;
        end
        FN_FEATURE: if (idx < NF) begin
          feat_off[idx] = off;
          feat_gain[idx] = gain;
        end
        FN_SAMPLE: begin
          if (idx < NF) begin
            q = qround((longint'(smp) - longint'(feat_off[idx])) * longint'(feat_gain[idx]),
                       in_shift);
            for (int j = 0; j < NH; j++)
              hid_acc[j] = hid_acc[j] + 32'(q * longint'(l1_w[idx*NH + j]));
          end
          if (is_last) begin
            logit = out_bias;
            for (int j = 0; j < NH; j++) begin
              pre = longint'($signed(hid_acc[j])) + longint'(unit_bias[j]);
              h = (pre > 0) ? qround(pre * longint'(hid_mult), hid_shift) : 0;
              logit += h * longint'(l2_w[j]);
              hid_acc[j] = '0;
            end
            if (logit > 64'sd2147483647) logit = 64'sd2147483647;
            if (logit < -64'sd2147483648) logit = -64'sd2147483648;
            exp_logits.push_back(32'(logit));
          end
        end
      endcase
    endfunction

    function void check_result(logic cls, logic signed [31:0] logit);
      logic signed [31:0] want;
      results_seen++;
      if (exp_logits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: logit %0d", logit);
        return;
      end
      want = exp_logits.pop_front();
      if (logit !== want || cls !== (want >= 0)) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected class %0d logit %0d, got class %0d logit %0d",
                   want >= 0, want, cls, logit);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic in_tlast = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mlp_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  int8_mlp_binary_classifier DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, $signed(out_tdata));
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles with no beat accepted anywhere
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_int8_mlp_binary_classifier NOT OK");
      $finish;
    end
  end

  task automatic send_beat(func_t fn, logic [10:0] idx, logic signed [7:0] w,
                           logic signed [31:0] b, logic signed [15:0] off,
                           logic [23:0] gain, logic signed [15:0] smp, bit is_last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tdata <= {5'b0, smp, gain, off, b, w, idx};
    in_tuser <= fn;
    in_tlast <= is_last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_beat(fn, idx, w, b, off, gain, smp, is_last);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // idle point: input stopped, all results in, block given time to settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.exp_logits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] ob, logic [23:0] hm, logic [5:0] hs, logic [5:0] is);
    write_cfg(CFG_OUTPUT_BIAS, ob);
    write_cfg(CFG_HIDDEN_MULT, hm);
    write_cfg(CFG_HIDDEN_SHFT, hs);
    write_cfg(CFG_INPUT_SHFT, is);
  endtask

  function automatic logic [23:0] pick_gain();
    return 24'($urandom_range(0, (1 << $urandom_range(1, 24)) - 1));
  endfunction

  // one random vector of samples, or now and then a random setup beat
  task automatic random_item(ref int count);
    int n;
    logic [10:0] idx;
    if ($urandom_range(99) < 12) begin
      send_beat(func_t'($urandom_range(0, 2)), 11'($urandom), 8'($urandom), $urandom,
                16'($urandom), pick_gain(), 16'($urandom), 1'($urandom));
      count++;
      return;
    end
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      idx = ($urandom_range(99) < 6) ? 11'($urandom_range(NF, 2047))
                                     : 11'($urandom_range(0, NUSED-1));
      send_beat(FN_SAMPLE, idx, 8'($urandom), $urandom, 16'($urandom), 24'($urandom),
                16'($urandom), k == n - 1);
      count++;
    end
  endtask

  initial begin
    int count;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the stores behind every feature that samples use
    set_regs(32'd0, 24'd65536, 6'd16, 6'd16);
    for (int i = 0; i < NUSED*NH; i++)
      send_beat(FN_L1_WEIGHT, 11'(i), 8'($urandom), $urandom, 16'($urandom), 24'($urandom),
                16'($urandom), 1'($urandom));
    for (int j = 0; j < NH; j++)
      send_beat(FN_UNIT, 11'(j), 8'($urandom), 32'($signed($urandom_range(0, 200000)) - 50000),
                16'($urandom), 24'($urandom), 16'($urandom), 1'($urandom));
    for (int f = 0; f < NUSED; f++)
      send_beat(FN_FEATURE, 11'(f), 8'($urandom), $urandom, 16'($urandom), pick_gain(),
                16'($urandom), 1'($urandom));

    // directed: field extremes and the special cases
    send_beat(FN_FEATURE, 11'd0, 8'sd0, 0, -16'sd32768, 24'hffffff, 16'sd0, 1'b0);
    send_beat(FN_FEATURE, 11'd1, 8'sd0, 0, 16'sd32767, 24'h0, 16'sd0, 1'b0);
    send_beat(FN_L1_WEIGHT, 11'd0, -8'sd128, 0, 16'sd0, 24'd0, 16'sd0, 1'b0);
    send_beat(FN_L1_WEIGHT, 11'd2047, 8'sd127, -1, -16'sd1, 24'hffffff, -16'sd1, 1'b1);
    send_beat(FN_UNIT, 11'd0, 8'sd127, 32'h7fffffff, 16'sd0, 24'd0, 16'sd0, 1'b0);
    send_beat(FN_UNIT, 11'd1, -8'sd128, 32'h80000000, 16'sd0, 24'd0, 16'sd0, 1'b0);
    // setup beats past their store, ignored
    send_beat(FN_UNIT, 11'd2047, 8'sd5, 32'd7, 16'sd0, 24'd0, 16'sd0, 1'b0);
    send_beat(FN_FEATURE, 11'd2047, 8'sd0, 0, 16'sd123, 24'd99, 16'sd0, 1'b0);
    send_beat(FN_SAMPLE, 11'd0, 8'sd0, 0, 16'sd0, 24'd0, 16'sd32767, 1'b0);
    send_beat(FN_SAMPLE, 11'd1, 8'sd0, 0, 16'sd0, 24'd0, -16'sd32768, 1'b1);
    send_beat(FN_SAMPLE, 11'd0, 8'sd0, 0, 16'sd0, 24'd0, -16'sd32768, 1'b1);
    // out-of-range sample index still closes the vector
    send_beat(FN_SAMPLE, 11'd2047, 8'sd0, 0, 16'sd0, 24'd0, 16'sd100, 1'b1);
    send_beat(FN_SAMPLE, 11'd5, 8'sd0, 0, 16'sd0, 24'd0, 16'sd1000, 1'b1);
    drain();
    // zero shifts, largest shifts, saturating logit both ways
    set_regs(32'h7fffffff, 24'hffffff, 6'd0, 6'd0);
    send_beat(FN_SAMPLE, 11'd0, 8'sd0, 0, 16'sd0, 24'd0, 16'sd32767, 1'b1);
    send_beat(FN_SAMPLE, 11'd3, 8'sd0, 0, 16'sd0, 24'd0, -16'sd7, 1'b1);
    drain();
    set_regs(32'h80000000, 24'd0, 6'd63, 6'd63);
    send_beat(FN_SAMPLE, 11'd4, 8'sd0, 0, 16'sd0, 24'd0, 16'sd32767, 1'b1);
    drain();
    set_regs(32'h80000000, 24'hffffff, 6'd0, 6'd0);
    send_beat(FN_SAMPLE, 11'd0, 8'sd0, 0, 16'sd0, 24'd0, 16'sd32767, 1'b1);
    drain();

    // random phases, each with its own settings and idle pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;
          set_regs(32'd0, 24'd65536, 6'd16, 6'd16);
        end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;
          set_regs($urandom, 24'($urandom), 6'($urandom_range(8, 30)), 6'($urandom_range(10, 24)));
        end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72;
          set_regs(32'h7fffff00, 24'hffffff, 6'd47, 6'd0);
        end
        default: begin send_idle_pct = 38; recv_stall_pct = 38;
          set_regs(32'h80000100, 24'($urandom), 6'($urandom_range(0, 63)), 6'd47);
        end
      endcase
      count = 0;
      while (count < PHASE_ITEMS) random_item(count);
      drain();
    end

    $display("covered %0d input beats and %0d result beats over four idle patterns",
             sb.beats_seen, sb.results_seen);
    $display("register settings included zero and maximum shifts and saturating biases");
    if (sb.mismatches == 0 && sb.exp_logits.size() == 0) begin
      $display("tb_int8_mlp_binary_classifier OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.exp_logits.size());
      $display("tb_int8_mlp_binary_classifier NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/imlp_pkg.sv
rtl/int8_mlp_binary_classifier.sv
rtl/imlp_checker.sv
test/tb_int8_mlp_binary_classifier.sv
